// ===== src/sfx_pkg.sv =====
// ----------------------------------------------------------------------------
// Soundex encoder package
// Shared constants, digit tables, queue entry and result types.
// ----------------------------------------------------------------------------
package sfx_pkg;

    // Code store depth: default and the top of its range.
    localparam int MAX_CODE_DEF = 16;
    localparam int MAX_CODE_HI  = 64;
    // Character counts hold any value up to the largest store depth.
    localparam int CNT_W        = $clog2(MAX_CODE_HI + 1);
    // Entries in the front-to-back queue.
    localparam int Q_DEPTH_DEF  = 4;

    localparam logic [3:0] NO_DIGIT    = 4'd15;
    localparam logic [4:0] MAX_LEN_RST = 5'd4;

    // Configuration register indexes.
    localparam logic CFG_IDX_REFINED = 1'b0;
    localparam logic CFG_IDX_MAX_LEN = 1'b1;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_H = 8'h48;
    localparam logic [7:0] CH_UPPER_W = 8'h57;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // Letter-to-digit tables, A through Z.
    localparam logic [3:0] STD_DIGIT [26] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd5,
        4'd5, 4'd0, 4'd1, 4'd2, 4'd6, 4'd2, 4'd3, 4'd0, 4'd1, 4'd0, 4'd2, 4'd0, 4'd2
    };
    localparam logic [3:0] REF_DIGIT [26] = '{
        4'd0, 4'd1, 4'd3, 4'd6, 4'd0, 4'd2, 4'd4, 4'd0, 4'd0, 4'd4, 4'd3, 4'd7, 4'd8,
        4'd8, 4'd0, 4'd1, 4'd5, 4'd9, 4'd3, 4'd6, 4'd0, 4'd2, 4'd0, 4'd5, 4'd0, 4'd5
    };

    // One transaction from the front to the back: up to two code characters
    // and, on the last item of a word, the emit length of the code.
    typedef struct packed {
        logic [1:0]       nch;
        logic [7:0]       c0;
        logic [7:0]       c1;
        logic             is_end;
        logic             is_empty;
        logic [CNT_W-1:0] n_out;
        logic [CNT_W-1:0] n_chars;
    } t_ent;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_empty;
        logic       is_last;
    } t_res;

    function automatic logic [3:0] digit_of(input logic [4:0] idx, input logic refined);
        logic [3:0] d;
        d = 4'd0;
        if (idx <= 5'd25) begin
            d = refined ? REF_DIGIT[idx] : STD_DIGIT[idx];
        end
        return d;
    endfunction

endpackage

// ===== src/sfx_queue.sv =====
// ----------------------------------------------------------------------------
// Soundex entry queue
// Small register FIFO that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module sfx_queue #(
    parameter int DEPTH = sfx_pkg::Q_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfx_pkg::t_ent i_data,
    output logic          o_full,
    input  logic          i_pop,
    output sfx_pkg::t_ent o_data,
    output logic          o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    sfx_pkg::t_ent r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/sfx_front.sv =====
// ----------------------------------------------------------------------------
// Soundex front end
// Classifies each byte, tracks the word state and forwards code characters.
// ----------------------------------------------------------------------------
module sfx_front #(
    parameter int MAX_CODE = sfx_pkg::MAX_CODE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_refined,
    input  logic [4:0]    i_max_len,
    input  logic          i_accept,
    input  logic          i_has_char,
    input  logic [7:0]    i_char_in,
    input  logic          i_word_end,
    output logic          o_q_push,
    output sfx_pkg::t_ent o_q_data
);

    localparam int CW = sfx_pkg::CNT_W;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_CODE);
    localparam logic [CW:0]   MAX_CX = (CW + 1)'(MAX_CODE);

    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_CODE = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [3:0]    r_prev, n_prev;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_ns, n_ns;

    logic [7:0]    upc, dch;
    logic [4:0]    idx;
    logic [3:0]    dig;
    logic          is_letter, is_white, room, single;
    logic [1:0]    nch;
    logic [7:0]    c0, c1;
    logic [CW:0]   total, limit, n_emit;

    always_comb begin
        upc = i_char_in;
        if (i_char_in >= sfx_pkg::CH_LOWER_A && i_char_in <= sfx_pkg::CH_LOWER_Z) begin
            upc = i_char_in - sfx_pkg::CASE_DELTA;
        end
        is_letter = (upc >= sfx_pkg::CH_UPPER_A) && (upc <= sfx_pkg::CH_UPPER_Z);
        idx       = 5'(upc - sfx_pkg::CH_UPPER_A);
        dig       = sfx_pkg::digit_of(idx, i_refined);
        dch       = sfx_pkg::CH_ZERO + {4'd0, dig};
        is_white  = (i_char_in == sfx_pkg::CH_SPACE) ||
                    (i_char_in >= sfx_pkg::CH_TAB && i_char_in <= sfx_pkg::CH_CR);
        room      = (r_cnt < MAX_C);

        n_phase = r_phase;
        n_prev  = r_prev;
        n_ns    = r_ns;
        nch     = 2'd0;
        c0      = upc;
        c1      = dch;

        if (i_has_char) begin
            if (!is_white && r_ns != 2'd2) begin
                n_ns = r_ns + 2'd1;
            end
            if (r_phase != PH_STOP) begin
                if (!is_letter) begin
                    if (r_phase == PH_CODE) begin
                        n_phase = PH_STOP;
                    end
                end else if (r_phase == PH_SEEK) begin
                    // First letter: keep it; refined also keeps its digit.
                    nch     = i_refined ? 2'd2 : 2'd1;
                    n_prev  = dig;
                    n_phase = PH_CODE;
                end else if (i_refined) begin
                    if (dig != r_prev) begin
                        c0     = dch;
                        nch    = room ? 2'd1 : 2'd0;
                        n_prev = dig;
                    end
                end else begin
                    if (dig != 4'd0 && dig != r_prev) begin
                        c0     = dch;
                        nch    = room ? 2'd1 : 2'd0;
                        n_prev = dig;
                    end
                    // A vowel breaks a run of equal digits; H and W do not.
                    if (dig == 4'd0 && upc != sfx_pkg::CH_UPPER_H &&
                        upc != sfx_pkg::CH_UPPER_W) begin
                        n_prev = sfx_pkg::NO_DIGIT;
                    end
                end
            end
        end
        n_cnt = r_cnt + CW'(nch);

        // Emit length: padded in standard mode, then cut to max_len and depth.
        total  = i_refined ? {1'b0, n_cnt} : {1'b0, n_cnt} + (CW + 1)'(4);
        limit  = ((CW + 1)'(i_max_len) < MAX_CX) ? (CW + 1)'(i_max_len) : MAX_CX;
        n_emit = (total < limit) ? total : limit;
        single = i_refined && (n_ns == 2'd1);

        o_q_data.nch      = nch;
        o_q_data.c0       = c0;
        o_q_data.c1       = c1;
        o_q_data.is_end   = i_word_end;
        o_q_data.is_empty = (n_phase == PH_SEEK) || (!single && n_emit == '0);
        o_q_data.n_out    = single ? CW'(1) : n_emit[CW-1:0];
        o_q_data.n_chars  = n_cnt;
    end

    assign o_q_push = i_accept && (nch != 2'd0 || i_word_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_prev  <= 4'd0;
            r_cnt   <= '0;
            r_ns    <= 2'd0;
        end else if (i_accept) begin
            if (i_word_end) begin
                r_phase <= PH_SEEK;
                r_prev  <= 4'd0;
                r_cnt   <= '0;
                r_ns    <= 2'd0;
            end else begin
                r_phase <= n_phase;
                r_prev  <= n_prev;
                r_cnt   <= n_cnt;
                r_ns    <= n_ns;
            end
        end
    end

endmodule

// ===== src/sfx_back.sv =====
// ----------------------------------------------------------------------------
// Soundex back end
// Collects a word's code characters, then drains them with padding.
// ----------------------------------------------------------------------------
module sfx_back #(
    parameter int MAX_CODE = sfx_pkg::MAX_CODE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sfx_pkg::t_ent i_q_data,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output sfx_pkg::t_res o_res
);

    localparam int CW = sfx_pkg::CNT_W;
    localparam int AW = $clog2(MAX_CODE);

    localparam logic [1:0] BK_COLLECT = 2'd0;
    localparam logic [1:0] BK_SECOND  = 2'd1;
    localparam logic [1:0] BK_EMIT    = 2'd2;

    logic [1:0]    r_state, n_state;
    sfx_pkg::t_ent r_hold;
    logic [AW-1:0] r_wr;
    logic [CW-1:0] r_k;
    logic [7:0]    r_store [MAX_CODE];
    logic [7:0]    r_rd_data;
    logic          r_p_valid, r_p_pad, r_p_empty, r_p_last;

    sfx_pkg::t_res r_ob [2];
    logic          r_ob_wr, r_ob_rd;
    logic [1:0]    r_ob_cnt;

    logic          wr_en, issue, k_last, out_pop;
    logic [7:0]    wr_data;
    logic [CW-1:0] n_eff;
    logic [2:0]    occ;
    sfx_pkg::t_res p_res;

    assign o_q_pop = (r_state == BK_COLLECT) && !i_q_empty;
    assign out_pop = i_pop && (r_ob_cnt != 2'd0);
    assign n_eff   = r_hold.is_empty ? CW'(1) : r_hold.n_out;
    assign k_last  = (r_k == n_eff - CW'(1));
    assign occ     = 3'(r_ob_cnt) + 3'(r_p_valid) - 3'(out_pop);
    assign issue   = (r_state == BK_EMIT) && (occ < 3'd2);

    always_comb begin
        wr_en   = 1'b0;
        wr_data = i_q_data.c0;
        n_state = r_state;
        unique case (r_state)
            BK_COLLECT: begin
                if (o_q_pop) begin
                    wr_en = (i_q_data.nch != 2'd0);
                    if (i_q_data.nch == 2'd2) begin
                        n_state = BK_SECOND;
                    end else if (i_q_data.is_end) begin
                        n_state = BK_EMIT;
                    end
                end
            end
            BK_SECOND: begin
                wr_en   = 1'b1;
                wr_data = r_hold.c1;
                n_state = r_hold.is_end ? BK_EMIT : BK_COLLECT;
            end
            BK_EMIT: begin
                if (issue && k_last) begin
                    n_state = BK_COLLECT;
                end
            end
            default: begin
                n_state = BK_COLLECT;
            end
        endcase
    end

    always_comb begin
        p_res.ch       = r_p_empty ? 8'd0 : (r_p_pad ? sfx_pkg::CH_ZERO : r_rd_data);
        p_res.is_empty = r_p_empty;
        p_res.is_last  = r_p_last;
    end

    assign o_empty = (r_ob_cnt == 2'd0);
    assign o_res   = r_ob[r_ob_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_COLLECT;
            r_wr      <= '0;
            r_k       <= '0;
            r_p_valid <= 1'b0;
            r_ob_wr   <= 1'b0;
            r_ob_rd   <= 1'b0;
            r_ob_cnt  <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= issue;
            if (r_state == BK_EMIT && n_state == BK_COLLECT) begin
                r_wr <= '0;
                r_k  <= '0;
            end else begin
                if (wr_en) begin
                    r_wr <= r_wr + AW'(1);
                end
                if (issue) begin
                    r_k <= r_k + CW'(1);
                end
            end
            if (r_p_valid) begin
                r_ob_wr <= !r_ob_wr;
            end
            if (out_pop) begin
                r_ob_rd <= !r_ob_rd;
            end
            r_ob_cnt <= r_ob_cnt + 2'(r_p_valid) - 2'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_hold <= i_q_data;
        end
        if (wr_en) begin
            r_store[r_wr] <= wr_data;
        end
        if (issue) begin
            r_rd_data <= r_store[r_k[AW-1:0]];
            r_p_pad   <= (r_k >= r_hold.n_chars);
            r_p_empty <= r_hold.is_empty;
            r_p_last  <= k_last;
        end
        if (r_p_valid) begin
            r_ob[r_ob_wr] <= p_res;
        end
    end

endmodule

// ===== src/soundex_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Soundex encoder unit
// Streams the bytes of words and returns standard or refined Soundex codes.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------
//  input    | push / full            | i_has_char, i_char_in, i_word_end
//  result   | pop / empty            | o_code_char, o_code_empty, o_code_last
//  config   | i_cfg_wen (no wait)    | i_cfg_idx, i_cfg_data
//
//  The front takes one byte per cycle while the entry queue has room.
//  The back pops a word's queued entries (a refined first letter needs a
//  second store write), then reads its code out; its single store port sets
//  that cost while the queue lets the next word stream in. A read passes a
//  register, then the output buffer. Synchronous reset (active-low) clears
//  control, not data. A full queue stalls input; a held result stalls the back.
//
module soundex_encoder_unit #(
    parameter int MAX_CODE = sfx_pkg::MAX_CODE_DEF,
    parameter int Q_DEPTH  = sfx_pkg::Q_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       push,
    output logic       full,
    input  logic       i_has_char,
    input  logic [7:0] i_char_in,
    input  logic       i_word_end,
    // result channel
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_code_char,
    output logic       o_code_empty,
    output logic       o_code_last,
    // configuration port
    input  logic       i_cfg_wen,
    input  logic       i_cfg_idx,
    input  logic [4:0] i_cfg_data
);

    // Config: user writes only while no transaction is in flight; not enforced.
    logic       r_refined;
    logic [4:0] r_max_len;

    logic          accept;
    logic          q_push, q_pop, q_full, q_empty;
    sfx_pkg::t_ent q_in, q_out;
    sfx_pkg::t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refined <= 1'b0;
            r_max_len <= sfx_pkg::MAX_LEN_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                sfx_pkg::CFG_IDX_REFINED: r_refined <= i_cfg_data[0];
                sfx_pkg::CFG_IDX_MAX_LEN: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept a byte whenever the entry queue can take what it produces.
    assign full   = q_full;
    assign accept = push && !q_full;

    sfx_front #(
        .MAX_CODE (MAX_CODE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_refined  (r_refined),
        .i_max_len  (r_max_len),
        .i_accept   (accept),
        .i_has_char (i_has_char),
        .i_char_in  (i_char_in),
        .i_word_end (i_word_end),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    // Entry queue: code characters and the end-of-word record of each word.
    sfx_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Back end: gather the word, then drain its code through a 2-entry buffer.
    sfx_back #(
        .MAX_CODE (MAX_CODE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_code_char  = res.ch;
    assign o_code_empty = res.is_empty;
    assign o_code_last  = res.is_last;

endmodule

// ===== src/sfx_checker.sv =====
// ----------------------------------------------------------------------------
// Soundex encoder checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sfx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_code_char,
    input logic       o_code_empty,
    input logic       o_code_last
);

    // Reset drains both sides.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not idle after reset");

    // An empty code is a single transaction with a zero character.
    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_code_empty) |-> (o_code_char == 8'd0 && o_code_last))
        else $error("empty code result malformed");

    // Every other code character is an upper-case letter or a digit.
    a_code_alnum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_code_empty) |->
            ((o_code_char >= 8'h30 && o_code_char <= 8'h39) ||
             (o_code_char >= 8'h41 && o_code_char <= 8'h5A)))
        else $error("code character out of alphabet");

    // A result not taken holds.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_code_char) && $stable(o_code_last)))
        else $error("waiting result changed");

endmodule

bind soundex_encoder_unit sfx_checker u_sfx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_code_char  (o_code_char),
    .o_code_empty (o_code_empty),
    .o_code_last  (o_code_last)
);

// ===== sim/sfx_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Soundex encoder scoreboard
// Predicts the code characters of each word from the accepted bytes and
// checks the encoder's results against them in order.
// ----------------------------------------------------------------------------
package sfx_tb_pkg;

    localparam int    CODE_DEPTH = sfx_pkg::MAX_CODE_DEF;
    localparam string STD_CODES  = "01230120022455012623010202";
    localparam string REF_CODES  = "01360240043788015936020505";

    typedef enum logic [1:0] {SEEK_LETTER, CODING, STOPPED} t_word_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       empty;
        logic       last;
    } t_code_item;

    class sfx_code_scoreboard;
        bit          refined;
        bit [4:0]    max_len;
        t_word_phase phase;
        bit [3:0]    last_digit;
        bit [7:0]    store [CODE_DEPTH];
        int unsigned n_stored;
        int unsigned n_nonspace;
        t_code_item  codes_due [$];
        int unsigned n_results;
        int unsigned errors;

        function new();
            refined   = 1'b0;
            max_len   = sfx_pkg::MAX_LEN_RST;
            n_results = 0;
            errors    = 0;
            clear_word();
        endfunction

        function void clear_word();
            phase      = SEEK_LETTER;
            last_digit = 4'd0;
            n_stored   = 0;
            n_nonspace = 0;
        endfunction

        function void set_reg(bit idx, bit [4:0] data);
            if (idx == sfx_pkg::CFG_IDX_REFINED) begin
                refined = data[0];
            end else begin
                max_len = data;
            end
        endfunction

        function int unsigned pending();
            return codes_due.size();
        endfunction

        // Drop characters beyond the store depth.
        function void keep_char(bit [7:0] c);
            if (n_stored < CODE_DEPTH) begin
                store[n_stored] = c;
                n_stored++;
            end
        endfunction

        function void expect_code(bit [7:0] c, bit is_empty, bit is_last);
            t_code_item item;
            item.ch    = c;
            item.empty = is_empty;
            item.last  = is_last;
            codes_due.push_back(item);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH %s", msg);
        endtask

        // Fold one accepted transaction into the word and, on its last item,
        // queue the code characters it must produce.
        function void note_byte(bit has, bit [7:0] c, bit fin);
            bit [7:0]    u;
            bit [7:0]    sym;
            bit [3:0]    d;
            int unsigned total;
            int unsigned limit;
            int unsigned n;
            if (has) begin
                if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) && n_nonspace < 2) begin
                    n_nonspace++;
                end
                u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
                if (u < "A" || u > "Z") begin
                    if (phase == CODING) phase = STOPPED;
                end else if (phase != STOPPED) begin
                    sym = refined ? REF_CODES[u - "A"] : STD_CODES[u - "A"];
                    d   = sym[3:0];
                    if (phase == SEEK_LETTER) begin
                        keep_char(u);
                        if (refined) keep_char(sym);
                        last_digit = d;
                        phase      = CODING;
                    end else if (refined) begin
                        if (d != last_digit) begin
                            keep_char(sym);
                            last_digit = d;
                        end
                    end else begin
                        if (d != 4'd0 && d != last_digit) begin
                            keep_char(sym);
                            last_digit = d;
                        end
                        // vowels break a run, H and W do not
                        if (d == 4'd0 && u != "H" && u != "W") last_digit = sfx_pkg::NO_DIGIT;
                    end
                end
            end
            if (!fin) return;

            n = 0;
            if (phase != SEEK_LETTER) begin
                if (refined && n_nonspace == 1) begin
                    expect_code(store[0], 1'b0, 1'b1);
                    clear_word();
                    return;
                end
                total = refined ? n_stored : n_stored + 4;
                limit = (max_len < CODE_DEPTH) ? max_len : CODE_DEPTH;
                n     = (total < limit) ? total : limit;
            end
            if (n == 0) begin
                expect_code(8'h00, 1'b1, 1'b1);
            end else begin
                for (int unsigned k = 0; k < n; k++) begin
                    expect_code((k < n_stored) ? store[k] : 8'h30, 1'b0, k + 1 == n);
                end
            end
            clear_word();
        endfunction

        task check_code(logic [7:0] ch, logic is_empty, logic is_last);
            t_code_item want;
            n_results++;
            if (codes_due.size() == 0) begin
                report($sformatf("result %0d: none due, got char %02h empty %b last %b",
                                 n_results, ch, is_empty, is_last));
                return;
            end
            want = codes_due.pop_front();
            if (ch !== want.ch) begin
                report($sformatf("result %0d: code_char %02h, due %02h",
                                 n_results, ch, want.ch));
            end
            if (is_empty !== want.empty) begin
                report($sformatf("result %0d: code_empty %b, due %b",
                                 n_results, is_empty, want.empty));
            end
            if (is_last !== want.last) begin
                report($sformatf("result %0d: code_last %b, due %b",
                                 n_results, is_last, want.last));
            end
        endtask
    endclass

endpackage

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Soundex encoder unit testbench
// Streams words into the encoder byte by byte, predicts every code character
// with the scoreboard and checks the results in order. A directed part hits
// the special cases, then random phases sweep both modes and the code length
// limit under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Random budget; each phase overshoots by part of a word, so together
    // with the directed part the run sends about 310 transactions.
    localparam int          RANDOM_ITEMS  = 250;
    localparam int          N_PHASES      = 10;
    // Quiet cycles after the last result before touching the registers.
    localparam int          SETTLE_CYCLES = 24;
    localparam int unsigned RUN_LIMIT_NS  = 3_000_000;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       push       = 1'b0;
    logic       i_has_char = 1'b0;
    logic [7:0] i_char_in  = 8'h00;
    logic       i_word_end = 1'b0;
    logic       pop        = 1'b0;
    logic       i_cfg_wen  = 1'b0;
    logic       i_cfg_idx  = 1'b0;
    logic [4:0] i_cfg_data = 5'd0;
    logic       full;
    logic       empty;
    logic [7:0] o_code_char;
    logic       o_code_empty;
    logic       o_code_last;

    sfx_tb_pkg::sfx_code_scoreboard sb;
    int unsigned        items_sent = 0;
    int unsigned        stall_left = 0;
    // Steady stretches: no idling on that side for a whole phase.
    bit                 in_steady  = 1'b0;
    bit                 out_steady = 1'b0;

    soundex_encoder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_has_char   (i_has_char),
        .i_char_in    (i_char_in),
        .i_word_end   (i_word_end),
        .empty        (empty),
        .pop          (pop),
        .o_code_char  (o_code_char),
        .o_code_empty (o_code_empty),
        .o_code_last  (o_code_last),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(24, 4);
    endfunction

    function automatic bit [7:0] pick_letter();
        return ($urandom_range(1) != 0 ? 8'h61 : 8'h41) + 8'($urandom_range(25));
    endfunction

    // Tab through carriage return, or space.
    function automatic bit [7:0] pick_blank();
        int unsigned r;
        r = $urandom_range(5);
        return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
    endfunction

    // Offer one transaction after an optional gap and hold it until taken.
    // Push stays high straight into the next item when there is no gap.
    task automatic send_item(input bit has, input bit [7:0] c, input bit fin);
        int unsigned idle;
        idle = in_steady ? 0 : draw_gap();
        if (idle != 0) begin
            push <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        push       <= 1'b1;
        i_has_char <= has;
        i_char_in  <= c;
        i_word_end <= fin;
        // full read right after the edge is the value the block saw at it
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_byte(has, c, fin);
        items_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(1'b1, s[i], i == s.len() - 1);
        end
    endtask

    // One random word. Most are names with random letters, the rest are lone
    // bytes among blanks, raw noise and words without any byte.
    task automatic send_word();
        bit [7:0]    text [$];
        bit [7:0]    c;
        int unsigned kind;
        int unsigned len;
        bit          split_end;
        kind = $urandom_range(99);
        if (kind < 70) begin
            if ($urandom_range(4) == 0) text.push_back(pick_blank());
            len = ($urandom_range(4) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            repeat (len) text.push_back(pick_letter());
            if ($urandom_range(3) == 0) begin
                // a non-letter stops the coding; letters after it are dead
                do c = 8'($urandom); while ((c | 8'h20) >= "a" && (c | 8'h20) <= "z");
                text.push_back(c);
                repeat ($urandom_range(3)) text.push_back(pick_letter());
            end
        end else if (kind < 82) begin
            repeat ($urandom_range(2)) text.push_back(pick_blank());
            text.push_back($urandom_range(2) != 0 ? pick_letter() : 8'($urandom_range(255)));
            repeat ($urandom_range(2)) text.push_back(pick_blank());
        end else if (kind < 94) begin
            repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
        end
        // Close the word on an item without a byte now and then.
        split_end = (text.size() == 0) || ($urandom_range(6) == 0);
        foreach (text[i]) begin
            if ($urandom_range(11) == 0) send_item(1'b0, 8'($urandom), 1'b0);
            send_item(1'b1, text[i], !split_end && i == text.size() - 1);
        end
        if (split_end) send_item(1'b0, 8'($urandom), 1'b1);
    endtask

    // Write both registers on back-to-back cycles; the write enable stays
    // high across them. Junk above bit 0 checks that the mode takes one bit.
    task automatic write_regs(input bit refined, input bit [4:0] len);
        bit [4:0] mode_word;
        mode_word  = {4'($urandom), refined};
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= sfx_pkg::CFG_IDX_REFINED;
        i_cfg_data <= mode_word;
        @(posedge i_clk);
        sb.set_reg(sfx_pkg::CFG_IDX_REFINED, mode_word);
        i_cfg_idx  <= sfx_pkg::CFG_IDX_MAX_LEN;
        i_cfg_data <= len;
        @(posedge i_clk);
        sb.set_reg(sfx_pkg::CFG_IDX_MAX_LEN, len);
        i_cfg_wen  <= 1'b0;
    endtask

    // Stop offering, wait for every due code character, then let the
    // back end settle so the block is idle before the next register write.
    task automatic drain_phase();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: check each popped code character, then pick the next
    // cycle's pop with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && empty === 1'b0) begin
                sb.check_code(o_code_char, o_code_empty, o_code_last);
            end
            if (stall_left != 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                stall_left = out_steady ? 0 : draw_gap();
            end
        end
    end

    initial begin
        int unsigned goal;
        bit [4:0]    len;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Standard mode at reset settings (max length 4). In this name H
        // sits between two equal digits and a later vowel breaks the run.
        send_string("Ashcraft");
        // word closed by an item without a byte, and nothing before it
        send_item(1'b0, 8'hA5, 1'b1);
        // bytes at both ends of the range, no letter: empty code
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1);
        // leading blank skipped, lowercase first letter, filler item,
        // coding stops at the digit, padding fills the rest
        send_item(1'b1, 8'h20, 1'b0);
        send_item(1'b1, "z", 1'b0);
        send_item(1'b0, "Q", 1'b0);
        send_item(1'b1, "1", 1'b0);
        send_item(1'b1, "b", 1'b1);
        drain_phase();

        // Refined mode, length above range: a lone letter among blanks
        // gives just that letter; a repeated digit is dropped.
        write_regs(1'b1, 5'd31);
        send_item(1'b1, 8'h0A, 1'b0);
        send_item(1'b1, "q", 1'b0);
        send_item(1'b1, 8'h20, 1'b1);
        send_string("Bb");
        drain_phase();

        // Zero length cuts every standard code to nothing.
        write_regs(1'b0, 5'd0);
        send_string("ab");
        drain_phase();

        // Random phases alternate the mode and sweep the length limit.
        for (int p = 0; p < N_PHASES; p++) begin
            in_steady  = ($urandom_range(3) == 0);
            out_steady = ($urandom_range(3) == 0);
            unique case (p)
                0, 1:    len = 5'd31;
                2, 5:    len = 5'd0;
                3:       len = 5'd16;
                4:       len = 5'd1;
                6:       len = 5'($urandom_range(15, 2));
                7:       len = 5'($urandom_range(30, 17));
                8:       len = 5'd4;
                default: len = 5'($urandom);
            endcase
            write_regs(p % 2 != 0, len);
            goal = items_sent + RANDOM_ITEMS / N_PHASES;
            while (items_sent < goal) send_word();
            drain_phase();
        end

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop if the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
